### design/refcounted_signature_dedup_table_macros.svh
// assertion helpers for the dedup table checker
`ifndef REFCOUNTED_SIGNATURE_DEDUP_TABLE_MACROS_SVH
`define REFCOUNTED_SIGNATURE_DEDUP_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define RSDT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dedup table check failed");

// next-cycle implication
`define RSDT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dedup table check failed");

`endif

### design/rsdt_pkg.sv
`timescale 1ns / 1ps
package rsdt_pkg;

  typedef enum logic [1:0] {
    CMD_FOLD    = 2'd0,
    CMD_RETAIN  = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_LOOKUP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_CREATED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  localparam logic [63:0] MIX_MULT  = 64'hff51afd7ed558ccd;
  localparam int unsigned MIX_SHIFT = 33;
  localparam int unsigned LEN_SHIFT = 32;
  localparam logic [31:0] COUNT_MAX = 32'hffffffff;

  typedef struct packed {
    cmd_e        command;
    logic [63:0] sig_hash;
    logic [31:0] sig_length;
    logic [31:0] sig_head_mask;
    logic [31:0] target_id;
  } req_t;

  typedef struct packed {
    logic [31:0] result_id;
    status_e     status;
    logic [31:0] ref_count;
    logic [63:0] out_hash;
    logic [31:0] out_length;
    logic [31:0] out_head_mask;
  } rsp_t;

  // request after key mixing, handed from front to back
  typedef struct packed {
    cmd_e        command;
    logic [63:0] key;
    logic [63:0] sig_hash;
    logic [31:0] sig_length;
    logic [31:0] sig_head_mask;
    logic [31:0] target_id;
  } work_t;

endpackage

### design/rsdt_front.sv
`timescale 1ns / 1ps
module rsdt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rsdt_pkg::req_t req_i,
  output logic          push_o,
  output rsdt_pkg::work_t work_o,
  input  logic          full_i
);
  import rsdt_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_PRE  = 3'd1;
  localparam logic [2:0] F_P0   = 3'd2;
  localparam logic [2:0] F_P1   = 3'd3;
  localparam logic [2:0] F_P2   = 3'd4;
  localparam logic [2:0] F_P3   = 3'd5;
  localparam logic [2:0] F_PUSH = 3'd6;

  logic [2:0]  state_q, state_d;
  req_t        req_q, req_d;
  logic [63:0] x_q, x_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] prod_q, prod_d;
  logic [63:0] pre;
  logic [63:0] lo_full;
  logic [31:0] mul_a, mul_b, mul_lo;

  assign pre = req_q.sig_hash ^ ({32'b0, req_q.sig_length} << LEN_SHIFT)
             ^ {32'b0, req_q.sig_head_mask};
  assign lo_full = 64'(x_q[31:0]) * 64'(MIX_MULT[31:0]);
  // shared multiplier for the two cross terms, low half only
  assign mul_a  = (state_q == F_P1) ? x_q[31:0] : x_q[63:32];
  assign mul_b  = (state_q == F_P1) ? MIX_MULT[63:32] : MIX_MULT[31:0];
  assign mul_lo = mul_a * mul_b;

  assign busy   = (state_q != F_IDLE);
  assign push_o = (state_q == F_PUSH) && !full_i;

  always_comb begin
    work_o.command       = req_q.command;
    work_o.key           = acc_q ^ (acc_q >> MIX_SHIFT);
    work_o.sig_hash      = req_q.sig_hash;
    work_o.sig_length    = req_q.sig_length;
    work_o.sig_head_mask = req_q.sig_head_mask;
    work_o.target_id     = req_q.target_id;
  end

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    x_d     = x_q;
    acc_d   = acc_q;
    prod_d  = prod_q;
    unique case (state_q)
      F_IDLE: begin
        if (start) begin
          req_d   = req_i;
          state_d = F_PRE;
        end
      end
      F_PRE: begin
        x_d     = pre ^ (pre >> MIX_SHIFT);
        state_d = F_P0;
      end
      F_P0: begin
        acc_d   = lo_full;
        state_d = F_P1;
      end
      F_P1: begin
        prod_d  = mul_lo;
        state_d = F_P2;
      end
      F_P2: begin
        acc_d   = acc_q + {prod_q, 32'b0};
        prod_d  = mul_lo;
        state_d = F_P3;
      end
      F_P3: begin
        acc_d   = acc_q + {prod_q, 32'b0};
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    x_q    <= x_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
  end

endmodule

### design/rsdt_queue.sv
`timescale 1ns / 1ps
module rsdt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rsdt_pkg::work_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output rsdt_pkg::work_t data_o,
  output logic            empty_o
);
  import rsdt_pkg::*;

  localparam int unsigned DEPTH = 2;

  work_t       slot_q [DEPTH];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;

  assign full_o  = (count_q == 2'(DEPTH));
  assign empty_o = (count_q == 2'd0);
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= data_i;
  end

endmodule

### design/rsdt_back.sv
`timescale 1ns / 1ps
module rsdt_back #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  rsdt_pkg::work_t data_i,
  output logic            pop_o,
  output logic            done_o,
  output rsdt_pkg::rsp_t  rsp_o
);
  import rsdt_pkg::*;

  localparam int unsigned IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNTW = IDXW + 1;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_SCAN = 2'd1;
  localparam logic [1:0] B_EXEC = 2'd2;

  typedef struct packed {
    logic [31:0] id;
    logic [63:0] key;
    logic [63:0] hash;
    logic [31:0] length;
    logic [31:0] head_mask;
    logic [31:0] refs;
  } entry_t;

  entry_t mem_q [ENTRIES];
  entry_t rdata_q;

  logic [1:0]         state_q, state_d;
  work_t              work_q, work_d;
  logic [CNTW-1:0]    addr_q, addr_d;
  logic               rv_q, rv_d;
  logic [IDXW-1:0]    ridx_q, ridx_d;
  logic               hit_q, hit_d;
  logic [IDXW-1:0]    hit_idx_q, hit_idx_d;
  entry_t             hit_ent_q, hit_ent_d;
  logic               free_q, free_d;
  logic [IDXW-1:0]    free_idx_q, free_idx_d;
  logic [31:0]        next_id_q, next_id_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  rsp_t               rsp_q, rsp_d;
  logic               done_q, done_d;

  logic               re, we;
  logic [IDXW-1:0]    waddr;
  entry_t             wdata;
  logic               is_fold, match;
  logic [31:0]        cnt;

  assign is_fold = (work_q.command == CMD_FOLD);
  assign match   = valid_q[ridx_q] && (is_fold ? (rdata_q.key == work_q.key)
                                               : (rdata_q.id == work_q.target_id));
  assign done_o  = done_q;
  assign rsp_o   = rsp_q;

  always_comb begin
    state_d    = state_q;
    work_d     = work_q;
    addr_d     = addr_q;
    rv_d       = 1'b0;
    ridx_d     = ridx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_ent_d  = hit_ent_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    next_id_d  = next_id_q;
    valid_d    = valid_q;
    rsp_d      = rsp_q;
    done_d     = 1'b0;
    pop_o      = 1'b0;
    re         = 1'b0;
    we         = 1'b0;
    waddr      = hit_idx_q;
    wdata      = hit_ent_q;
    cnt        = hit_ent_q.refs;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          work_d  = data_i;
          addr_d  = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
          state_d = B_SCAN;
        end
      end
      B_SCAN: begin
        // one table read per cycle, evaluated in the following cycle
        if (addr_q != CNTW'(ENTRIES)) begin
          re     = 1'b1;
          ridx_d = addr_q[IDXW-1:0];
          rv_d   = 1'b1;
          addr_d = addr_q + CNTW'(1);
        end
        if (rv_q) begin
          if (match) begin
            hit_d     = 1'b1;
            hit_idx_d = ridx_q;
            hit_ent_d = rdata_q;
            state_d   = B_EXEC;
          end else begin
            if (is_fold && !valid_q[ridx_q] && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = ridx_q;
            end
            if (ridx_q == IDXW'(ENTRIES - 1)) state_d = B_EXEC;
          end
        end
      end
      B_EXEC: begin
        rsp_d           = '0;
        rsp_d.result_id = work_q.target_id;
        rsp_d.status    = ST_NOT_FOUND;
        if (is_fold) begin
          if (hit_q) begin
            cnt             = (hit_ent_q.refs == COUNT_MAX) ? hit_ent_q.refs
                                                            : hit_ent_q.refs + 32'd1;
            we              = 1'b1;
            wdata.refs      = cnt;
            rsp_d.result_id = hit_ent_q.id;
            rsp_d.status    = ST_FOUND;
            rsp_d.ref_count = cnt;
          end else if (free_q) begin
            we               = 1'b1;
            waddr            = free_idx_q;
            wdata.id         = next_id_q;
            wdata.key        = work_q.key;
            wdata.hash       = work_q.sig_hash;
            wdata.length     = work_q.sig_length;
            wdata.head_mask  = work_q.sig_head_mask;
            wdata.refs       = 32'd1;
            valid_d[free_idx_q] = 1'b1;
            next_id_d        = next_id_q + 32'd1;
            rsp_d.result_id  = next_id_q;
            rsp_d.status     = ST_CREATED;
            rsp_d.ref_count  = 32'd1;
          end else begin
            rsp_d.status = ST_FULL;
          end
        end else if (hit_q) begin
          rsp_d.status = ST_FOUND;
          unique case (work_q.command)
            CMD_RETAIN: begin
              cnt        = (hit_ent_q.refs == COUNT_MAX) ? hit_ent_q.refs
                                                         : hit_ent_q.refs + 32'd1;
              we         = 1'b1;
              wdata.refs = cnt;
            end
            CMD_RELEASE: begin
              cnt        = (hit_ent_q.refs != 32'd0) ? hit_ent_q.refs - 32'd1
                                                     : hit_ent_q.refs;
              we         = 1'b1;
              wdata.refs = cnt;
              if (cnt == 32'd0) valid_d[hit_idx_q] = 1'b0;
            end
            CMD_LOOKUP: begin
              rsp_d.out_hash      = hit_ent_q.hash;
              rsp_d.out_length    = hit_ent_q.length;
              rsp_d.out_head_mask = hit_ent_q.head_mask;
            end
            default: cnt = hit_ent_q.refs;
          endcase
          rsp_d.ref_count = cnt;
        end
        done_d  = 1'b1;
        state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      rv_q      <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      next_id_q <= 32'd0;
      valid_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      rv_q      <= rv_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      next_id_q <= next_id_d;
      valid_q   <= valid_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q     <= work_d;
    addr_q     <= addr_d;
    ridx_q     <= ridx_d;
    hit_idx_q  <= hit_idx_d;
    hit_ent_q  <= hit_ent_d;
    free_idx_q <= free_idx_d;
    rsp_q      <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[addr_q[IDXW-1:0]];
  end

endmodule

### design/refcounted_signature_dedup_table.sv
`timescale 1ns / 1ps
// Dedup table of folded path signatures with reference counts. A request is
// taken when start is high and busy is low; its single result appears on
// rsp_o for exactly one cycle with done_o high, and the receiver cannot stall
// it. The front keeps busy high while it mixes the fold key through one
// 32x32 full-product multiplier and one shared 32x32 low-half multiplier,
// then hands the request to a two-deep queue, so busy drops again while
// the back is still working. The back scans the entry memory one entry
// per cycle through its single read port, stopping at the first match, and
// then updates at most one entry; that scan limits the sustained throughput.
// Valid bits live in flip-flops, so there is no clearing pass after reset.
module refcounted_signature_dedup_table #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  rsdt_pkg::req_t req_i,
  output logic           done_o,
  output rsdt_pkg::rsp_t rsp_o
);
  import rsdt_pkg::*;

  logic  push, full, pop, empty;
  work_t work_in, work_out;

  rsdt_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .push_o (push),
    .work_o (work_in),
    .full_i (full)
  );

  rsdt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (work_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (work_out),
    .empty_o (empty)
  );

  rsdt_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .data_i  (work_out),
    .pop_o   (pop),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

endmodule

### design/rsdt_checker.sv
`timescale 1ns / 1ps
`include "refcounted_signature_dedup_table_macros.svh"
module rsdt_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input rsdt_pkg::rsp_t rsp_o
);
  import rsdt_pkg::*;

  logic accept, miss_rsp, sig_zero;
  assign accept   = start && !busy;
  assign miss_rsp = done_o && (rsp_o.status == ST_NOT_FOUND || rsp_o.status == ST_FULL);
  assign sig_zero = (rsp_o.out_hash == 64'd0) && (rsp_o.out_length == 32'd0)
                  && (rsp_o.out_head_mask == 32'd0);

  // a miss or full table reports no count
  `RSDT_ASSERT_NOW(a_miss_zero, miss_rsp, rsp_o.ref_count == 32'd0)
  // signature fields only come back with a hit
  `RSDT_ASSERT_NOW(a_sig_zero, done_o && rsp_o.status != ST_FOUND, sig_zero)
  // a new entry starts with one reference
  `RSDT_ASSERT_NOW(a_create_one, done_o && rsp_o.status == ST_CREATED, rsp_o.ref_count == 32'd1)
  // results never come in adjacent cycles
  `RSDT_ASSERT_NEXT(a_done_gap, done_o, !done_o)
  // an accepted request keeps the front busy
  `RSDT_ASSERT_NEXT(a_busy_after, accept, busy)

endmodule

bind refcounted_signature_dedup_table rsdt_checker u_chk (.*);

### tb/sv/dedup_table_checker.sv
`timescale 1ns / 1ps
module dedup_table_checker #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           busy,
  input  rsdt_pkg::req_t req_i,
  input  logic           done_o,
  input  rsdt_pkg::rsp_t rsp_o,
  output int             fail_count,
  output int             pending
);
  import rsdt_pkg::*;

  logic        tbl_valid [ENTRIES];
  logic [31:0] tbl_id    [ENTRIES];
  logic [63:0] tbl_key   [ENTRIES];
  logic [63:0] tbl_hash  [ENTRIES];
  logic [31:0] tbl_len   [ENTRIES];
  logic [31:0] tbl_mask  [ENTRIES];
  logic [31:0] tbl_refs  [ENTRIES];
  logic [31:0] id_ctr;
  rsp_t        rsp_queue [$];
  int          reported;

  function automatic logic [63:0] fold_key(logic [63:0] h, logic [31:0] l, logic [31:0] m);
    logic [63:0] x;
    x = h ^ ({32'd0, l} << LEN_SHIFT) ^ {32'd0, m};
    x = x ^ (x >> MIX_SHIFT);
    x = x * MIX_MULT;
    x = x ^ (x >> MIX_SHIFT);
    return x;
  endfunction

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == COUNT_MAX) ? v : v + 32'd1;
  endfunction

  task automatic apply_request(input req_t r);
    rsp_t        p;
    logic [63:0] k;
    int          hit;
    int          slot;
    hit = -1;
    slot = -1;
    p = '0;
    p.result_id = r.target_id;
    p.status = ST_NOT_FOUND;
    if (r.command == CMD_FOLD) begin
      k = fold_key(r.sig_hash, r.sig_length, r.sig_head_mask);
      for (int i = 0; i < ENTRIES; i++)
        if (hit < 0 && tbl_valid[i] && tbl_key[i] == k) hit = i;
      for (int i = 0; i < ENTRIES; i++)
        if (slot < 0 && !tbl_valid[i]) slot = i;
      if (hit >= 0) begin
        tbl_refs[hit] = bump(tbl_refs[hit]);
        p.result_id = tbl_id[hit];
        p.ref_count = tbl_refs[hit];
        p.status = ST_FOUND;
      end else if (slot >= 0) begin
        tbl_valid[slot] = 1'b1;
        tbl_id[slot] = id_ctr;
        tbl_key[slot] = k;
        tbl_hash[slot] = r.sig_hash;
        tbl_len[slot] = r.sig_length;
        tbl_mask[slot] = r.sig_head_mask;
        tbl_refs[slot] = 32'd1;
        p.result_id = id_ctr;
        p.ref_count = 32'd1;
        p.status = ST_CREATED;
        id_ctr = id_ctr + 32'd1;
      end else begin
        p.status = ST_FULL;
      end
    end else begin
      for (int i = 0; i < ENTRIES; i++)
        if (hit < 0 && tbl_valid[i] && tbl_id[i] == r.target_id) hit = i;
      if (hit >= 0) begin
        p.status = ST_FOUND;
        case (r.command)
          CMD_RETAIN: tbl_refs[hit] = bump(tbl_refs[hit]);
          CMD_RELEASE: begin
            if (tbl_refs[hit] != 0) tbl_refs[hit] = tbl_refs[hit] - 32'd1;
            if (tbl_refs[hit] == 0) tbl_valid[hit] = 1'b0;
          end
          default: begin
            p.out_hash = tbl_hash[hit];
            p.out_length = tbl_len[hit];
            p.out_head_mask = tbl_mask[hit];
          end
        endcase
        p.ref_count = tbl_refs[hit];
      end
    end
    rsp_queue.push_back(p);
  endtask

  task automatic note_mismatch(input string what, input rsp_t e, input rsp_t a);
    fail_count++;
    if (reported < 10) begin
      reported++;
      $display("mismatch %s: expected id=%h st=%0d refs=%h h=%h l=%h m=%h",
               what, e.result_id, e.status, e.ref_count, e.out_hash, e.out_length,
               e.out_head_mask);
      $display("           actual   id=%h st=%0d refs=%h h=%h l=%h m=%h",
               a.result_id, a.status, a.ref_count, a.out_hash, a.out_length,
               a.out_head_mask);
    end
  endtask

  always @(posedge clk_i) begin
    rsp_t e;
    if (!rst_ni) begin
      fail_count = 0;
      reported = 0;
      id_ctr = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        tbl_valid[i] = 1'b0;
        tbl_refs[i] = '0;
      end
      rsp_queue.delete();
    end else begin
      // result of an earlier request goes out before this cycle's request is modeled
      if (done_o) begin
        if (rsp_queue.size() == 0) begin
          note_mismatch("unexpected", '0, rsp_o);
        end else begin
          e = rsp_queue.pop_front();
          if (e !== rsp_o) note_mismatch("field", e, rsp_o);
        end
      end
      if (start && !busy) apply_request(req_i);
    end
    pending <= rsp_queue.size();
  end
endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import rsdt_pkg::*;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  req_t  req_i = '0;
  logic  done_o;
  rsp_t  rsp_o;
  int    fail_count;
  int    pending;
  logic [63:0] seen_hash [$];

  always #10 clk_i = ~clk_i;

  refcounted_signature_dedup_table dut (.*);

  dedup_table_checker chk (.*);

  // start stays high across back-to-back requests; idle periods drop it
  task automatic send(input req_t r);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  function automatic req_t mk(cmd_e c, logic [63:0] h, logic [31:0] l, logic [31:0] m,
                              logic [31:0] t);
    req_t r;
    r.command = c;
    r.sig_hash = h;
    r.sig_length = l;
    r.sig_head_mask = m;
    r.target_id = t;
    return r;
  endfunction

  function automatic logic [31:0] rnd32();
    return $urandom();
  endfunction

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  initial begin
    req_t r;
    int   burst;
    int   n;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, every command, id not found
    send(mk(CMD_LOOKUP, '1, '1, '1, 32'd0));
    send(mk(CMD_FOLD, '0, '0, '0, '1));
    send(mk(CMD_FOLD, '1, '1, '1, '0));
    send(mk(CMD_FOLD, '0, '0, '0, '0));
    send(mk(CMD_RETAIN, '0, '0, '0, 32'd0));
    send(mk(CMD_LOOKUP, '0, '0, '0, 32'd0));
    send(mk(CMD_LOOKUP, '0, '0, '0, 32'd1));
    send(mk(CMD_RELEASE, '0, '0, '0, 32'd1));
    send(mk(CMD_LOOKUP, '0, '0, '0, 32'd1));
    send(mk(CMD_RETAIN, '1, '1, '1, '1));
    send(mk(CMD_RELEASE, '1, '1, '1, '1));
    send(mk(CMD_RELEASE, '0, '0, '0, 32'd0));
    send(mk(CMD_RELEASE, '0, '0, '0, 32'd0));
    send(mk(CMD_RELEASE, '0, '0, '0, 32'd0));
    send(mk(CMD_LOOKUP, '0, '0, '0, 32'd0));
    wait_idle();
    // fill the table and overflow it
    for (int i = 0; i < 70; i++)
      send(mk(CMD_FOLD, {rnd32(), rnd32()}, rnd32(), rnd32(), rnd32()));
    send(mk(CMD_FOLD, '1, '1, '1, '1));
    wait_idle();
    // random: mostly ids near the allocated range, hashes reused for fold hits
    n = 0;
    while (n < 465) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++) begin
        r = mk(cmd_e'($urandom_range(0, 3)), {rnd32(), rnd32()}, rnd32(), rnd32(),
               $urandom_range(0, 90));
        if ($urandom_range(0, 9) == 0) r.target_id = rnd32();
        if (r.command == CMD_FOLD) begin
          if (seen_hash.size() > 0 && $urandom_range(0, 2) == 0) begin
            r.sig_hash = seen_hash[$urandom_range(0, seen_hash.size() - 1)];
            r.sig_length = '0;
            r.sig_head_mask = '0;
          end else if (seen_hash.size() < 40) begin
            r.sig_length = '0;
            r.sig_head_mask = '0;
            seen_hash.push_back(r.sig_hash);
          end
        end
        send(r);
        n++;
      end
      if ($urandom_range(0, 1) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 90)) @(posedge clk_i);
      end
      if (n > 250 && n < 275) wait_idle();
    end
    wait_idle();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule
